[hdl/gnt_pkg.sv]
package gnt_pkg;

	// Character codes the scanner tests for.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam int NAME_BYTES  = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_NONTERM = 3'd0,
		KIND_TERM    = 3'd1,
		KIND_FUNC    = 3'd2,
		KIND_ASSIGN  = 3'd3,
		KIND_PERIOD  = 3'd4,
		KIND_BAR     = 3'd5,
		KIND_END     = 3'd6,
		KIND_ERROR   = 3'd7
	} kind_t;

	typedef enum logic [8:0] {
		PH_START   = 9'b000000001,
		PH_COMMENT = 9'b000000010,
		PH_LT      = 9'b000000100,
		PH_NT      = 9'b000001000,
		PH_TERM    = 9'b000010000,
		PH_AT      = 9'b000100000,
		PH_FUNC    = 9'b001000000,
		PH_COLON1  = 9'b010000000,
		PH_COLON2  = 9'b100000000
	} phase_t;

	typedef struct packed {
		kind_t        kind;
		logic [4:0]   len;
		logic [63:0]  chars_lo;
		logic [63:0]  chars_hi;
		logic [15:0]  line;
		logic [15:0]  column;
		logic         last;
	} token_t;

	// Up to two tokens come out of one character.
	typedef struct packed {
		logic   first_valid;
		logic   second_valid;
		token_t first;
		token_t second;
	} lex_res_t;

	typedef struct packed {
		logic   emit;
		kind_t  kind;
		phase_t phase;
		logic   halt;
		logic   name_begin;
	} start_res_t;

	function automatic logic is_name_start(logic [7:0] c);
		return (c == CH_UNDER) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_name_char(logic [7:0] c);
		return is_name_start(c) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_NL) || (c == CH_SPACE) || (c == CH_FF) || (c == CH_CR) ||
			(c == CH_TAB) || (c == CH_VT);
	endfunction

	// Decision taken when a character is examined in the start phase.
	function automatic start_res_t start_scan(logic [7:0] c, logic eoi);
		start_res_t r;
		r.emit = 1'b0;
		r.kind = KIND_END;
		r.phase = PH_START;
		r.halt = 1'b0;
		r.name_begin = 1'b0;
		if (eoi) begin
			r.emit = 1'b1;
			r.kind = KIND_END;
			r.halt = 1'b1;
		end else if (is_space(c)) begin
			r.phase = PH_START;
		end else if (c == CH_DOLLAR) begin
			r.phase = PH_COMMENT;
		end else if (c == CH_LT) begin
			r.phase = PH_LT;
		end else if (c == CH_AT) begin
			r.phase = PH_AT;
		end else if (c == CH_COLON) begin
			r.phase = PH_COLON1;
		end else if (c == CH_PERIOD) begin
			r.emit = 1'b1;
			r.kind = KIND_PERIOD;
		end else if (c == CH_BAR) begin
			r.emit = 1'b1;
			r.kind = KIND_BAR;
		end else if (is_name_start(c)) begin
			r.phase = PH_TERM;
			r.name_begin = 1'b1;
		end else begin
			r.emit = 1'b1;
			r.kind = KIND_ERROR;
			r.halt = 1'b1;
		end
		return r;
	endfunction

endpackage

[hdl/gnt_char_if.sv]
interface gnt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;

	modport source (output valid, output ch, output end_of_input, input ready);
	modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

[hdl/gnt_token_if.sv]
interface gnt_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [4:0]  name_length;
	logic [63:0] name_chars_low;
	logic [63:0] name_chars_high;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic        last_of_run;

	modport source (output valid, output token_kind, output name_length,
		output name_chars_low, output name_chars_high, output token_line,
		output token_column, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input name_length,
		input name_chars_low, input name_chars_high, input token_line,
		input token_column, input last_of_run, output ready);
endinterface

[hdl/gnt_lexer.sv]
module gnt_lexer #(
	parameter int NAME_MAX = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [7:0]       ch,
	input  logic             eoi,
	output gnt_pkg::lex_res_t res
);
	localparam int CNT_W = $clog2(NAME_MAX + 1);
	localparam int IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

	gnt_pkg::phase_t phase_q, phase_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [7:0]       name_q [NAME_MAX];
	logic [15:0]      line_q, line_n, col_q, col_n;
	logic [15:0]      st_line_q, st_line_n, st_col_q, st_col_n;
	logic             halted_q, halted_n;

	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       name_bytes [gnt_pkg::NAME_BYTES];
	logic [63:0]      chars_lo, chars_hi;
	gnt_pkg::start_res_t sr;
	gnt_pkg::token_t  name_tok;
	logic             can_keep;

	// Bytes at and beyond the kept length read as zero.
	for (genvar i = 0; i < gnt_pkg::NAME_BYTES; i++) begin : g_bytes
		if (i < NAME_MAX) begin : g_kept
			assign name_bytes[i] = (CNT_W'(i) < count_q) ? name_q[i] : 8'h00;
		end else begin : g_none
			assign name_bytes[i] = 8'h00;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			chars_lo[8*i +: 8] = name_bytes[i];
			chars_hi[8*i +: 8] = name_bytes[i+8];
		end
	end

	function automatic gnt_pkg::token_t plain_tok(gnt_pkg::kind_t k, logic [15:0] ln,
			logic [15:0] cl);
		gnt_pkg::token_t t;
		t = '0;
		t.kind = k;
		t.line = ln;
		t.column = cl;
		return t;
	endfunction

	assign can_keep = count_q < CNT_W'(NAME_MAX);
	assign sr = gnt_pkg::start_scan(ch, eoi);

	always_comb begin
		name_tok = '0;
		name_tok.kind = gnt_pkg::KIND_TERM;
		name_tok.len = 5'(count_q);
		name_tok.chars_lo = chars_lo;
		name_tok.chars_hi = chars_hi;
		name_tok.line = st_line_q;
		name_tok.column = st_col_q;
	end

	always_comb begin
		res = '0;
		phase_n = phase_q;
		count_n = count_q;
		wr_en = 1'b0;
		wr_idx = '0;
		st_line_n = st_line_q;
		st_col_n = st_col_q;
		halted_n = halted_q;
		line_n = line_q;
		col_n = col_q;
		if (go && !halted_q) begin
			case (phase_q)
				gnt_pkg::PH_START: begin
					st_line_n = line_q;
					st_col_n = col_q;
					res.first_valid = sr.emit;
					res.first = plain_tok(sr.kind, line_q, col_q);
					phase_n = sr.phase;
					halted_n = sr.halt;
					if (sr.name_begin) begin
						count_n = CNT_W'(1);
						wr_en = 1'b1;
					end
				end
				gnt_pkg::PH_COMMENT: begin
					if (eoi) begin
						res.first_valid = 1'b1;
						res.first = plain_tok(gnt_pkg::KIND_ERROR, st_line_q, st_col_q);
						halted_n = 1'b1;
					end else if (ch == gnt_pkg::CH_DOLLAR) begin
						phase_n = gnt_pkg::PH_START;
					end
				end
				gnt_pkg::PH_LT, gnt_pkg::PH_AT: begin
					if (!eoi && gnt_pkg::is_name_start(ch)) begin
						count_n = CNT_W'(1);
						wr_en = 1'b1;
						phase_n = (phase_q == gnt_pkg::PH_LT) ? gnt_pkg::PH_NT
							: gnt_pkg::PH_FUNC;
					end else begin
						res.first_valid = 1'b1;
						res.first = plain_tok(gnt_pkg::KIND_ERROR, st_line_q, st_col_q);
						halted_n = 1'b1;
					end
				end
				gnt_pkg::PH_NT: begin
					if (!eoi && ch == gnt_pkg::CH_GT) begin
						res.first_valid = 1'b1;
						res.first = name_tok;
						res.first.kind = gnt_pkg::KIND_NONTERM;
						phase_n = gnt_pkg::PH_START;
					end else if (!eoi && gnt_pkg::is_name_char(ch)) begin
						wr_en = can_keep;
						wr_idx = count_q[IDX_W-1:0];
						count_n = can_keep ? count_q + CNT_W'(1) : count_q;
					end else begin
						res.first_valid = 1'b1;
						res.first = plain_tok(gnt_pkg::KIND_ERROR, st_line_q, st_col_q);
						halted_n = 1'b1;
					end
				end
				gnt_pkg::PH_TERM, gnt_pkg::PH_FUNC: begin
					if (!eoi && gnt_pkg::is_name_char(ch)) begin
						wr_en = can_keep;
						wr_idx = count_q[IDX_W-1:0];
						count_n = can_keep ? count_q + CNT_W'(1) : count_q;
					end else begin
						// The name ends here and the same character is scanned again.
						res.first_valid = 1'b1;
						res.first = name_tok;
						res.first.kind = (phase_q == gnt_pkg::PH_TERM) ? gnt_pkg::KIND_TERM
							: gnt_pkg::KIND_FUNC;
						st_line_n = line_q;
						st_col_n = col_q;
						res.second_valid = sr.emit;
						res.second = plain_tok(sr.kind, line_q, col_q);
						phase_n = sr.phase;
						halted_n = sr.halt;
						if (sr.name_begin) begin
							count_n = CNT_W'(1);
							wr_en = 1'b1;
						end
					end
				end
				gnt_pkg::PH_COLON1: begin
					if (!eoi && ch == gnt_pkg::CH_COLON) begin
						phase_n = gnt_pkg::PH_COLON2;
					end else begin
						res.first_valid = 1'b1;
						res.first = plain_tok(gnt_pkg::KIND_ERROR, st_line_q, st_col_q);
						halted_n = 1'b1;
					end
				end
				gnt_pkg::PH_COLON2: begin
					if (!eoi && ch == gnt_pkg::CH_EQUAL) begin
						res.first_valid = 1'b1;
						res.first = plain_tok(gnt_pkg::KIND_ASSIGN, st_line_q, st_col_q);
						phase_n = gnt_pkg::PH_START;
					end else begin
						res.first_valid = 1'b1;
						res.first = plain_tok(gnt_pkg::KIND_ERROR, st_line_q, st_col_q);
						halted_n = 1'b1;
					end
				end
				default: begin
					phase_n = gnt_pkg::PH_START;
				end
			endcase
			res.first.last = !res.second_valid;
			res.second.last = 1'b1;
			if (!eoi) begin
				if (ch == gnt_pkg::CH_NL) begin
					line_n = (line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;
					col_n = '0;
				end else if (col_q != 16'hFFFF) begin
					col_n = col_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gnt_pkg::PH_START;
			count_q <= '0;
			line_q <= 16'd1;
			col_q <= 16'd1;
			st_line_q <= 16'd1;
			st_col_q <= 16'd1;
			halted_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			count_q <= count_n;
			line_q <= line_n;
			col_q <= col_n;
			st_line_q <= st_line_n;
			st_col_q <= st_col_n;
			halted_q <= halted_n;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			name_q[wr_idx] <= ch;
		end
	end

endmodule

[hdl/gnt_token_queue.sv]
module gnt_token_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  gnt_pkg::lex_res_t res,
	output logic              room,
	gnt_token_if.source       tokens
);
	gnt_pkg::token_t                mem_q [gnt_pkg::QUEUE_DEPTH];
	logic [gnt_pkg::QPTR_W-1:0]     wp_q, rp_q;
	logic [gnt_pkg::QCNT_W-1:0]     cnt_q;
	logic                           pop;
	logic [gnt_pkg::QCNT_W-1:0]     pushes;
	gnt_pkg::token_t                head;

	// Room for the two tokens that one character can cause.
	assign room = cnt_q <= gnt_pkg::QCNT_W'(gnt_pkg::QUEUE_DEPTH - 2);
	assign pop = tokens.valid && tokens.ready;
	assign pushes = gnt_pkg::QCNT_W'(res.first_valid) + gnt_pkg::QCNT_W'(res.second_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + gnt_pkg::QPTR_W'(pushes);
			rp_q <= rp_q + gnt_pkg::QPTR_W'(pop);
			cnt_q <= cnt_q + pushes - gnt_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res.first_valid) begin
			mem_q[wp_q] <= res.first;
		end
		if (res.second_valid) begin
			mem_q[wp_q + gnt_pkg::QPTR_W'(1)] <= res.second;
		end
	end

	assign head = mem_q[rp_q];
	assign tokens.valid = cnt_q != '0;
	assign tokens.token_kind = head.kind;
	assign tokens.name_length = head.len;
	assign tokens.name_chars_low = head.chars_lo;
	assign tokens.name_chars_high = head.chars_hi;
	assign tokens.token_line = head.line;
	assign tokens.token_column = head.column;
	assign tokens.last_of_run = head.last;

endmodule

[hdl/grammar_notation_tokenizer_core.sv]
// Grammar notation tokenizer. One character, or an end-of-input mark, is
// taken per beat on chars, and one token leaves per beat on tokens. The block
// accepts a character every cycle while the token queue has room: it is
// registered, scanned from that register, and its zero, one or two tokens
// enter a four-entry token queue. Input stalls only while the queue holds
// more than two tokens, which happens only when the token side stalls; with
// the token side always ready the queue never goes above two, since a
// character that ends a name and starts another token always follows one that
// yields nothing. After an end or error token every further character is
// accepted and dropped until reset.
module grammar_notation_tokenizer_core #(
	parameter int NAME_MAX = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	gnt_char_if.sink     chars,
	gnt_token_if.source  tokens
);
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eoi_s1;
	logic       room;
	logic       advance;
	logic       accept;
	gnt_pkg::lex_res_t res;

	assign advance = valid_s1 && room;
	assign chars.ready = !valid_s1 || room;
	assign accept = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= chars.ch;
			eoi_s1 <= chars.end_of_input;
		end
	end

	gnt_lexer #(
		.NAME_MAX(NAME_MAX)
	) u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.go(advance),
		.ch(ch_s1),
		.eoi(eoi_s1),
		.res(res)
	);

	gnt_token_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.res(res),
		.room(room),
		.tokens(tokens)
	);

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		res.second_valid |-> res.first_valid)
		else $error("second token without a first one");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.first_valid |-> room)
		else $error("token pushed into a full queue");

	a_halt_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(res.first_valid && res.first.last &&
			(res.first.kind == gnt_pkg::KIND_END || res.first.kind == gnt_pkg::KIND_ERROR))
		|=> !res.first_valid)
		else $error("token produced after end or error");

endmodule

[bench/gnt_token_checker.sv]
`timescale 1ns / 100ps

module gnt_token_checker #(
	parameter int NAME_MAX = 16
) (
	input  logic clk,
	input  logic arst_n,
	gnt_char_if  chars,
	gnt_token_if tokens,
	output int   errors,
	output int   outstanding
);
	gnt_pkg::phase_t  scan_st;
	logic [7:0]       name_buf [gnt_pkg::NAME_BYTES];
	int               name_cnt;
	logic [15:0]      cur_line;
	logic [15:0]      cur_col;
	logic [15:0]      tok_line;
	logic [15:0]      tok_col;
	logic             stopped;
	gnt_pkg::token_t  this_run [$];
	gnt_pkg::token_t  tokens_due [$];

	function automatic logic blank(logic [7:0] c);
		return c == gnt_pkg::CH_SPACE || c == gnt_pkg::CH_TAB || c == gnt_pkg::CH_NL ||
			c == gnt_pkg::CH_VT || c == gnt_pkg::CH_FF || c == gnt_pkg::CH_CR;
	endfunction

	function automatic logic word_start(logic [7:0] c);
		return c == gnt_pkg::CH_UNDER || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic word_char(logic [7:0] c);
		return word_start(c) || (c >= "0" && c <= "9");
	endfunction

	// Characters past the name limit are dropped without notice.
	function automatic void take(logic [7:0] c);
		if (name_cnt < NAME_MAX) begin
			name_buf[name_cnt] = c;
			name_cnt++;
		end
	endfunction

	function automatic gnt_pkg::token_t make_token(gnt_pkg::kind_t kind, logic with_name);
		gnt_pkg::token_t t;
		t = '0;
		t.kind = kind;
		if (with_name) begin
			t.len = 5'(name_cnt);
			for (int i = 0; i < name_cnt; i++) begin
				if (i < 8)
					t.chars_lo[8 * i +: 8] = name_buf[i];
				else
					t.chars_hi[8 * (i - 8) +: 8] = name_buf[i];
			end
		end
		t.line = tok_line;
		t.column = tok_col;
		return t;
	endfunction

	function automatic void emit_token(gnt_pkg::kind_t kind, logic with_name);
		if (this_run.size() < 2)
			this_run.push_back(make_token(kind, with_name));
	endfunction

	task automatic scan_char(logic [7:0] c, logic eoi);
		logic again;
		if (stopped)
			return;
		this_run.delete();
		// A name ended by a foreign character hands that character back to the
		// start state within the same beat.
		do begin
			again = 1'b0;
			case (scan_st)
				gnt_pkg::PH_START: begin
					tok_line = cur_line;
					tok_col = cur_col;
					if (eoi) begin
						emit_token(gnt_pkg::KIND_END, 1'b0);
						stopped = 1'b1;
					end else if (blank(c)) begin
						scan_st = gnt_pkg::PH_START;
					end else if (c == gnt_pkg::CH_DOLLAR) begin
						scan_st = gnt_pkg::PH_COMMENT;
					end else if (c == gnt_pkg::CH_LT) begin
						scan_st = gnt_pkg::PH_LT;
					end else if (c == gnt_pkg::CH_AT) begin
						scan_st = gnt_pkg::PH_AT;
					end else if (c == gnt_pkg::CH_COLON) begin
						scan_st = gnt_pkg::PH_COLON1;
					end else if (c == gnt_pkg::CH_PERIOD) begin
						emit_token(gnt_pkg::KIND_PERIOD, 1'b0);
					end else if (c == gnt_pkg::CH_BAR) begin
						emit_token(gnt_pkg::KIND_BAR, 1'b0);
					end else if (word_start(c)) begin
						name_cnt = 0;
						take(c);
						scan_st = gnt_pkg::PH_TERM;
					end else begin
						emit_token(gnt_pkg::KIND_ERROR, 1'b0);
						stopped = 1'b1;
					end
				end
				gnt_pkg::PH_COMMENT: begin
					if (eoi) begin
						emit_token(gnt_pkg::KIND_ERROR, 1'b0);
						stopped = 1'b1;
					end else if (c == gnt_pkg::CH_DOLLAR) begin
						scan_st = gnt_pkg::PH_START;
					end
				end
				gnt_pkg::PH_LT, gnt_pkg::PH_AT: begin
					if (!eoi && word_start(c)) begin
						name_cnt = 0;
						take(c);
						if (scan_st == gnt_pkg::PH_LT)
							scan_st = gnt_pkg::PH_NT;
						else
							scan_st = gnt_pkg::PH_FUNC;
					end else begin
						emit_token(gnt_pkg::KIND_ERROR, 1'b0);
						stopped = 1'b1;
					end
				end
				gnt_pkg::PH_NT: begin
					if (!eoi && c == gnt_pkg::CH_GT) begin
						emit_token(gnt_pkg::KIND_NONTERM, 1'b1);
						scan_st = gnt_pkg::PH_START;
					end else if (!eoi && word_char(c)) begin
						take(c);
					end else begin
						emit_token(gnt_pkg::KIND_ERROR, 1'b0);
						stopped = 1'b1;
					end
				end
				gnt_pkg::PH_TERM, gnt_pkg::PH_FUNC: begin
					if (!eoi && word_char(c)) begin
						take(c);
					end else begin
						if (scan_st == gnt_pkg::PH_TERM)
							emit_token(gnt_pkg::KIND_TERM, 1'b1);
						else
							emit_token(gnt_pkg::KIND_FUNC, 1'b1);
						scan_st = gnt_pkg::PH_START;
						again = 1'b1;
					end
				end
				gnt_pkg::PH_COLON1: begin
					if (!eoi && c == gnt_pkg::CH_COLON) begin
						scan_st = gnt_pkg::PH_COLON2;
					end else begin
						emit_token(gnt_pkg::KIND_ERROR, 1'b0);
						stopped = 1'b1;
					end
				end
				gnt_pkg::PH_COLON2: begin
					if (!eoi && c == gnt_pkg::CH_EQUAL) begin
						emit_token(gnt_pkg::KIND_ASSIGN, 1'b0);
						scan_st = gnt_pkg::PH_START;
					end else begin
						emit_token(gnt_pkg::KIND_ERROR, 1'b0);
						stopped = 1'b1;
					end
				end
				default: begin
					scan_st = gnt_pkg::PH_START;
					again = 1'b1;
				end
			endcase
		end while (again && !stopped);

		if (!eoi) begin
			if (c == gnt_pkg::CH_NL) begin
				if (cur_line != 16'hFFFF)
					cur_line++;
				cur_col = '0;
			end else if (cur_col != 16'hFFFF) begin
				cur_col++;
			end
		end

		if (this_run.size() > 0) begin
			this_run[this_run.size() - 1].last = 1'b1;
			foreach (this_run[i])
				tokens_due.push_back(this_run[i]);
			outstanding += this_run.size();
		end
	endtask

	task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			errors++;
		end
	endtask

	task automatic check_token();
		gnt_pkg::token_t want;
		if (tokens_due.size() == 0) begin
			$error("token_kind: expected no token, got %0d at line %0d column %0d",
				tokens.token_kind, tokens.token_line, tokens.token_column);
			errors++;
			return;
		end
		want = tokens_due.pop_front();
		outstanding--;
		compare_field("token_kind", 64'(want.kind), 64'(tokens.token_kind));
		compare_field("name_length", 64'(want.len), 64'(tokens.name_length));
		compare_field("name_chars_low", want.chars_lo, tokens.name_chars_low);
		compare_field("name_chars_high", want.chars_hi, tokens.name_chars_high);
		compare_field("token_line", 64'(want.line), 64'(tokens.token_line));
		compare_field("token_column", 64'(want.column), 64'(tokens.token_column));
		compare_field("last_of_run", 64'(want.last), 64'(tokens.last_of_run));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_st = gnt_pkg::PH_START;
			name_cnt = 0;
			cur_line = 16'd1;
			cur_col = 16'd1;
			tok_line = 16'd1;
			tok_col = 16'd1;
			stopped = 1'b0;
			tokens_due.delete();
			outstanding = 0;
			errors = 0;
		end else begin
			if (chars.valid && chars.ready)
				scan_char(chars.ch, chars.end_of_input);
			if (tokens.valid && tokens.ready)
				check_token();
		end
	end

endmodule

[bench/grammar_notation_tokenizer_core_tb.sv]
`timescale 1ns / 100ps

module grammar_notation_tokenizer_core_tb;
	localparam int NAME_MAX = 16;
	localparam int RX_HOLD  = 400;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   sent;
	logic calm;
	logic hold_rx;
	logic in_name;

	gnt_char_if  chars_if ();
	gnt_token_if tokens_if ();

	grammar_notation_tokenizer_core #(.NAME_MAX(NAME_MAX)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	gnt_token_checker #(.NAME_MAX(NAME_MAX)) token_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.chars       (chars_if),
		.tokens      (tokens_if),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Token side: random stalls in alternating stretches, plus one long hold on request.
	initial begin : rx_side
		int rx_steps;
		rx_steps = 0;
		tokens_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				hold_rx = 1'b0;
				tokens_if.ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end else if (!calm && (rx_steps / 256) % 2 == 1 && $urandom_range(0, 5) == 0) begin
				tokens_if.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				tokens_if.ready <= 1'b1;
				@(posedge clk);
			end
			rx_steps++;
		end
	end

	task automatic send_char(logic [7:0] c, logic eoi);
		if (!calm && (sent / 128) % 2 == 0 && $urandom_range(0, 4) == 0) begin
			chars_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch <= c;
		chars_if.end_of_input <= eoi;
		do @(posedge clk); while (!chars_if.ready);
		sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	task automatic drain();
		chars_if.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	function automatic logic [7:0] name_char(logic first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + r - 26);
		else if (r == 52)
			return gnt_pkg::CH_UNDER;
		return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0: return gnt_pkg::CH_SPACE;
			1: return gnt_pkg::CH_TAB;
			2: return gnt_pkg::CH_NL;
			3: return gnt_pkg::CH_VT;
			4: return gnt_pkg::CH_FF;
			default: return gnt_pkg::CH_CR;
		endcase
	endfunction

	// Mostly short names; now and then one long enough to be cut at the limit.
	task automatic send_name();
		int len;
		len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		send_char(name_char(1'b1), 1'b0);
		repeat (len - 1) send_char(name_char(1'b0), 1'b0);
	endtask

	// One well-formed lexeme. A bare name right after another bare name or a
	// function would merge with it, so a blank goes in between.
	task automatic send_lexeme();
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(0, 11);
		if (in_name && pick <= 1)
			send_char(gnt_pkg::CH_SPACE, 1'b0);
		in_name = 1'b0;
		case (pick)
			0, 1: begin
				send_name();
				in_name = 1'b1;
			end
			2: begin
				send_char(gnt_pkg::CH_AT, 1'b0);
				send_name();
				in_name = 1'b1;
			end
			3, 4: begin
				send_char(gnt_pkg::CH_LT, 1'b0);
				send_name();
				send_char(gnt_pkg::CH_GT, 1'b0);
			end
			5: send_text("::=");
			6: send_char(gnt_pkg::CH_PERIOD, 1'b0);
			7: send_char(gnt_pkg::CH_BAR, 1'b0);
			8: begin
				send_char(gnt_pkg::CH_DOLLAR, 1'b0);
				repeat ($urandom_range(0, 6)) begin
					do b = 8'($urandom_range(0, 255)); while (b == gnt_pkg::CH_DOLLAR);
					send_char(b, 1'b0);
				end
				send_char(gnt_pkg::CH_DOLLAR, 1'b0);
			end
			9, 10: repeat ($urandom_range(1, 3)) send_char(blank_char(), 1'b0);
			default: send_char(gnt_pkg::CH_NL, 1'b0);
		endcase
	endtask

	// The block stops for good on an end or error token, and reset comes only
	// once, so each run closes with one such case picked at random.
	task automatic send_final();
		case ($urandom_range(0, 9))
			0: send_char(8'($urandom_range(0, 255)), 1'b1);
			1: begin
				send_name();
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			2: begin
				send_char(gnt_pkg::CH_AT, 1'b0);
				send_name();
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			3: begin
				send_text("$ab");
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			4: begin
				send_char(gnt_pkg::CH_LT, 1'b0);
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			5: begin
				send_char(gnt_pkg::CH_LT, 1'b0);
				send_name();
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			6: send_text("::.");
			7: send_text("#");
			8: begin
				send_name();
				send_text("#");
			end
			default: begin
				send_char(gnt_pkg::CH_LT, 1'b0);
				send_name();
				send_text("-");
			end
		endcase
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		chars_if.valid <= 1'b0;
		chars_if.ch <= '0;
		chars_if.end_of_input <= 1'b0;
		calm = 1'b0;
		hold_rx = 1'b0;
		in_name = 1'b0;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every blank, each token kind but end and error, names ended by a
		// following token, and a comment holding the byte extremes.
		send_text(" \t");
		send_char(gnt_pkg::CH_CR, 1'b0);
		send_text("\f\v\n<_>z.@A|::=$");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(gnt_pkg::CH_DOLLAR, 1'b0);

		while (sent < 700)
			send_lexeme();

		// Hold the token side while periods and bars keep coming, so the block backs up.
		hold_rx = 1'b1;
		repeat (30) begin
			send_char(gnt_pkg::CH_PERIOD, 1'b0);
			send_char(gnt_pkg::CH_BAR, 1'b0);
		end
		in_name = 1'b0;
		drain();

		while (sent < 1250)
			send_lexeme();
		send_char(gnt_pkg::CH_NL, 1'b0);
		drain();

		// No idling on either side from here to the end.
		calm = 1'b1;
		while (sent < 1400)
			send_lexeme();
		send_text("<q> ");

		send_final();
		repeat (10) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		drain();
		repeat (20) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
